FILE: hdl/eptc_pkg.sv
// Shared types and constants for the epipole table core.
// No dependencies; used by eptc_ctl, eptc_dp and the top level.
package eptc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int ANG_W   = 24;
	localparam int OUT_W   = ANG_W + 1;
	localparam int POC_W   = 16;
	localparam int DIST_W  = POC_W + 2;

	localparam logic [2:0] FN_INSERT  = 3'd0;
	localparam logic [2:0] FN_MARK    = 3'd1;
	localparam logic [2:0] FN_LOOKUP  = 3'd2;
	localparam logic [2:0] FN_HAS     = 3'd3;
	localparam logic [2:0] FN_PREDICT = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NO_GLOBAL = 2'd3;

	localparam logic [1:0] MODE_CLOSEST = 2'd1;
	localparam logic [1:0] MODE_OLD_AVG = 2'd2;

	typedef struct packed {
		logic load;
		logic clr_idx;
		logic inc_idx;
		logic ins_do;
		logic mark;
		logic scan;
		logic pred_init;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       idx_end;
		logic       key_ge;
		logic       pred_on;
		logic       out_free;
	} sts_t;

endpackage

FILE: hdl/eptc_ctl.sv
// Sequencer for the epipole table core.
// Depends on eptc_pkg; drives eptc_dp through cmd_t, watches sts_t.
module eptc_ctl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  eptc_pkg::sts_t  sts,
	output eptc_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_INS_SCAN, S_INS_DO, S_MARK, S_PRED_INIT, S_SCAN, S_FINISH
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load    = in_valid;
				cmd.clr_idx = in_valid;
			end
			S_INS_SCAN: cmd.inc_idx = !(sts.idx_end || sts.key_ge);
			S_INS_DO:   cmd.ins_do = 1'b1;
			S_MARK:     cmd.mark = 1'b1;
			S_PRED_INIT: cmd.pred_init = 1'b1;
			S_SCAN: begin
				cmd.scan    = !sts.idx_end;
				cmd.inc_idx = !sts.idx_end;
			end
			S_FINISH:   cmd.finish = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECODE;
				S_DECODE: begin
					unique case (sts.func)
						eptc_pkg::FN_INSERT:  state_q <= S_INS_SCAN;
						eptc_pkg::FN_MARK:    state_q <= S_MARK;
						eptc_pkg::FN_LOOKUP,
						eptc_pkg::FN_HAS:     state_q <= S_SCAN;
						eptc_pkg::FN_PREDICT: state_q <= sts.pred_on ? S_PRED_INIT : S_FINISH;
						default:              state_q <= S_FINISH;
					endcase
				end
				S_INS_SCAN: if (sts.idx_end || sts.key_ge) state_q <= S_INS_DO;
				S_INS_DO:    state_q <= S_FINISH;
				S_MARK:      state_q <= S_FINISH;
				S_PRED_INIT: state_q <= S_SCAN;
				S_SCAN:      if (sts.idx_end) state_q <= S_FINISH;
				S_FINISH:    if (sts.out_free) state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/eptc_dp.sv
// Datapath of the epipole table core: sorted table, scan index, match and
// closest-distance trackers, result register. Depends on eptc_pkg.
module eptc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  eptc_pkg::cmd_t                      cmd,
	output eptc_pkg::sts_t                      sts,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_wdata,
	input  logic [2:0]                          func,
	input  logic signed [eptc_pkg::POC_W-1:0]   cur_pic,
	input  logic signed [eptc_pkg::POC_W-1:0]   ref_pic,
	input  logic signed [eptc_pkg::ANG_W-1:0]   theta_in,
	input  logic signed [eptc_pkg::ANG_W-1:0]   phi_in,
	input  logic                                avail_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic signed [eptc_pkg::OUT_W-1:0]   theta_out,
	output logic signed [eptc_pkg::OUT_W-1:0]   phi_out,
	output logic [1:0]                          status
);

	localparam int N  = eptc_pkg::ENTRIES;
	localparam int AW = eptc_pkg::ANG_W;
	localparam int PW = eptc_pkg::POC_W;
	localparam int DW = eptc_pkg::DIST_W;
	localparam logic [DW-1:0] D_INF = '1;

	// table
	logic signed [PW-1:0] kc_q [N];
	logic signed [PW-1:0] kr_q [N];
	logic signed [AW-1:0] th_q [N];
	logic signed [AW-1:0] ph_q [N];
	logic [N-1:0]         av_q;
	logic [eptc_pkg::CNT_W-1:0] cnt_q;
	logic [eptc_pkg::CNT_W-1:0] idx_q;
	logic [1:0] mode_q;

	// latched item
	logic [2:0]           fn_q;
	logic signed [PW-1:0] cur_q, ref_q;
	logic signed [AW-1:0] thi_q, phi_q;
	logic                 avi_q;

	// match and predictor trackers
	logic                 f0_q, f1_q, f2_q, full_q, glob_q;
	logic signed [AW-1:0] mt_q [3];
	logic signed [AW-1:0] mp_q [3];
	logic [DW-1:0]        d0_q, d1_q;
	logic signed [AW-1:0] t0_q, p0_q, t1_q, p1_q;

	logic [eptc_pkg::IDX_W-1:0] ri;
	logic signed [PW-1:0] rc, rr;
	logic signed [AW-1:0] rt, rp;
	logic                 ra;
	logic                 idx_end, key_eq, key_ge, out_free;
	logic signed [PW:0]   diff;
	logic [DW-1:0]        dist_abs;
	logic signed [AW:0]   sum_t, sum_p, hs_t, hs_p;
	logic signed [AW-1:0] h1_t, h1_p;

	function automatic logic signed [AW:0] OUT_EXT(input logic signed [AW-1:0] a);
		OUT_EXT = {a[AW-1], a};
	endfunction

	assign ri  = idx_q[eptc_pkg::IDX_W-1:0];
	assign rc  = kc_q[ri];
	assign rr  = kr_q[ri];
	assign rt  = th_q[ri];
	assign rp  = ph_q[ri];
	assign ra  = av_q[ri];
	assign idx_end = (idx_q >= cnt_q);
	assign key_eq  = (rc == cur_q) && (rr == ref_q);
	assign key_ge  = (rc > cur_q) || ((rc == cur_q) && (rr >= ref_q));
	assign out_free = !out_valid || !out_stall;

	assign diff = {cur_q[PW-1], cur_q} - {rc[PW-1], rc};
	assign dist_abs = diff[PW] ? DW'(-diff) : DW'(diff);

	// truncating halves
	assign sum_t = {t0_q[AW-1], t0_q} + {t1_q[AW-1], t1_q};
	assign sum_p = {p0_q[AW-1], p0_q} + {p1_q[AW-1], p1_q};
	assign hs_t  = (sum_t + $signed({{AW{1'b0}}, sum_t[AW]})) >>> 1;
	assign hs_p  = (sum_p + $signed({{AW{1'b0}}, sum_p[AW]})) >>> 1;
	assign h1_t  = (t1_q + $signed({{(AW-1){1'b0}}, t1_q[AW-1]})) >>> 1;
	assign h1_p  = (p1_q + $signed({{(AW-1){1'b0}}, p1_q[AW-1]})) >>> 1;

	always_comb begin
		sts.func     = fn_q;
		sts.idx_end  = idx_end;
		sts.key_ge   = key_ge;
		sts.pred_on  = (mode_q == eptc_pkg::MODE_CLOSEST) || (mode_q == eptc_pkg::MODE_OLD_AVG);
		sts.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			av_q      <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			mode_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + 1'b1;
			if (cmd.ins_do && idx_end && cnt_q != eptc_pkg::CNT_W'(N)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.ins_do && !key_eq && cnt_q != eptc_pkg::CNT_W'(N)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.ins_do) begin
				if (!idx_end && key_eq) begin
					av_q[ri] <= avi_q;
				end else if (cnt_q != eptc_pkg::CNT_W'(N)) begin
					for (int j = 1; j < N; j++) begin
						if (eptc_pkg::CNT_W'(j) > idx_q) av_q[j] <= av_q[j-1];
					end
					av_q[ri] <= avi_q;
				end
			end
			if (cmd.mark) begin
				for (int j = 0; j < N; j++) begin
					if (eptc_pkg::CNT_W'(j) < cnt_q && kc_q[j] == cur_q) av_q[j] <= 1'b1;
				end
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.finish) out_valid <= 1'b1;
		end
	end

	// table payload, item latch, trackers, result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fn_q   <= func;
			cur_q  <= cur_pic;
			ref_q  <= ref_pic;
			thi_q  <= theta_in;
			phi_q  <= phi_in;
			avi_q  <= avail_in;
			f0_q   <= 1'b0;
			f1_q   <= 1'b0;
			f2_q   <= 1'b0;
			full_q <= 1'b0;
			glob_q <= 1'b0;
		end
		if (cmd.ins_do) begin
			if (!idx_end && key_eq) begin
				th_q[ri] <= thi_q;
				ph_q[ri] <= phi_q;
			end else if (cnt_q == eptc_pkg::CNT_W'(N)) begin
				full_q <= 1'b1;
			end else begin
				for (int j = 1; j < N; j++) begin
					if (eptc_pkg::CNT_W'(j) > idx_q) begin
						kc_q[j] <= kc_q[j-1];
						kr_q[j] <= kr_q[j-1];
						th_q[j] <= th_q[j-1];
						ph_q[j] <= ph_q[j-1];
					end
				end
				kc_q[ri] <= cur_q;
				kr_q[ri] <= ref_q;
				th_q[ri] <= thi_q;
				ph_q[ri] <= phi_q;
			end
		end
		if (cmd.pred_init) begin
			// seed both slots from entry 0 with maximum distance
			t0_q <= th_q[0];
			p0_q <= ph_q[0];
			t1_q <= th_q[0];
			p1_q <= ph_q[0];
			d0_q <= D_INF;
			d1_q <= D_INF;
		end
		if (cmd.scan && ra) begin
			if (fn_q == eptc_pkg::FN_PREDICT) begin
				if (rc == -1 && rr == -1) glob_q <= 1'b1;
				if (dist_abs < d0_q) begin
					d0_q <= dist_abs;
					t0_q <= rt;
					p0_q <= rp;
				end else if (dist_abs < d1_q) begin
					d1_q <= dist_abs;
					t1_q <= rt;
					p1_q <= rp;
				end
			end else begin
				if (key_eq) begin
					f0_q <= 1'b1; mt_q[0] <= rt; mp_q[0] <= rp;
				end
				if (rc == cur_q && rr == -1) begin
					f1_q <= 1'b1; mt_q[1] <= rt; mp_q[1] <= rp;
				end
				if (rc == -1 && rr == -1) begin
					f2_q <= 1'b1; mt_q[2] <= rt; mp_q[2] <= rp;
				end
			end
		end
		if (cmd.finish) begin
			hit       <= 1'b0;
			theta_out <= '0;
			phi_out   <= '0;
			status    <= eptc_pkg::ST_OK;
			case (fn_q)
				eptc_pkg::FN_INSERT: if (full_q) status <= eptc_pkg::ST_FULL;
				eptc_pkg::FN_LOOKUP: begin
					if (f0_q) begin
						hit <= 1'b1; theta_out <= OUT_EXT(mt_q[0]); phi_out <= OUT_EXT(mp_q[0]);
					end else if (f1_q) begin
						hit <= 1'b1; theta_out <= OUT_EXT(mt_q[1]); phi_out <= OUT_EXT(mp_q[1]);
					end else if (f2_q) begin
						hit <= 1'b1; theta_out <= OUT_EXT(mt_q[2]); phi_out <= OUT_EXT(mp_q[2]);
					end else begin
						status <= eptc_pkg::ST_NOT_FOUND;
					end
				end
				eptc_pkg::FN_HAS: begin
					if (f0_q) hit <= 1'b1;
					else status <= eptc_pkg::ST_NOT_FOUND;
				end
				eptc_pkg::FN_PREDICT: begin
					if (sts.pred_on) begin
						if (!glob_q) begin
							status <= eptc_pkg::ST_NO_GLOBAL;
						end else if (d0_q == d1_q) begin
							if (mode_q == eptc_pkg::MODE_OLD_AVG) begin
								theta_out <= OUT_EXT(t0_q) + OUT_EXT(h1_t);
								phi_out   <= OUT_EXT(p0_q) + OUT_EXT(h1_p);
							end else begin
								theta_out <= hs_t;
								phi_out   <= hs_p;
							end
						end else begin
							theta_out <= OUT_EXT(t0_q);
							phi_out   <= OUT_EXT(p0_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/epipole_table_with_closest_predictor_core.sv
// Top level of the epipole table core: sequencer plus datapath.
// Depends on eptc_pkg, eptc_ctl and eptc_dp.
//
// Input channel (in_valid/in_stall) carries one operation per transfer:
// insert, make available, lookup, has or predict. Every operation returns
// exactly one result transfer on the output channel (out_valid/out_stall).
// prediction_mode is written through cfg_we/cfg_wdata; the user must write it
// only while idle, since the block does not enforce this. One operation at
// a time. The sequencer scans the table one entry per cycle through its
// single read port. The result sits in an output register, so the next
// item is taken while the previous result waits; if the receiver keeps
// stalling, the following result is held in its final step until the
// output register frees up.
// Reset empties the table, clears all availability marks and sets the
// mode to zero; no clearing pass is needed.
module epipole_table_with_closest_predictor_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          func,
	input  logic signed [eptc_pkg::POC_W-1:0]   cur_pic,
	input  logic signed [eptc_pkg::POC_W-1:0]   ref_pic,
	input  logic signed [eptc_pkg::ANG_W-1:0]   theta_in,
	input  logic signed [eptc_pkg::ANG_W-1:0]   phi_in,
	input  logic                                avail_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic signed [eptc_pkg::OUT_W-1:0]   theta_out,
	output logic signed [eptc_pkg::OUT_W-1:0]   phi_out,
	output logic [1:0]                          status
);

	eptc_pkg::cmd_t cmd;
	eptc_pkg::sts_t sts;

	eptc_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	eptc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.func      (func),
		.cur_pic   (cur_pic),
		.ref_pic   (ref_pic),
		.theta_in  (theta_in),
		.phi_in    (phi_in),
		.avail_in  (avail_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.theta_out (theta_out),
		.phi_out   (phi_out),
		.status    (status)
	);

endmodule
